FILE: sv/ip_header_field_extractor_top_assert.svh
// Assertion helpers used by the record emitter of the IP header field extractor.
`ifndef IP_HEADER_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define IP_HEADER_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// ante |-> cons, sampled on the rising clock, quiet during reset
`define IHFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ihfe check failed");
// ante |=> cons, cons checked in the cycle after ante
`define IHFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ihfe check failed");
`else
`define IHFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IHFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/ihfe_pkg.sv
`default_nettype none
package ihfe_pkg;
	localparam int HDR_SNAP_BYTES = 40;
	localparam int PKT_LEN_W      = 16;
	localparam int KIND_W         = 5;
	localparam int IDX_W          = 4;

	localparam logic [IDX_W-1:0] V4_LAST_IDX = 4'd11;
	localparam logic [IDX_W-1:0] V6_LAST_IDX = 4'd9;
	localparam logic [3:0] IHL_MIN = 4'd5;
	localparam logic [PKT_LEN_W-1:0] V6_MIN_LEN = 16'd40;

	localparam logic [KIND_W-1:0] K_VERSION = 5'd0;
	localparam logic [KIND_W-1:0] K_IHL     = 5'd1;
	localparam logic [KIND_W-1:0] K_DSCP    = 5'd2;
	localparam logic [KIND_W-1:0] K_ECN     = 5'd3;
	localparam logic [KIND_W-1:0] K_TOTLEN  = 5'd4;
	localparam logic [KIND_W-1:0] K_ID      = 5'd5;
	localparam logic [KIND_W-1:0] K_FRAG    = 5'd6;
	localparam logic [KIND_W-1:0] K_TTL     = 5'd7;
	localparam logic [KIND_W-1:0] K_PROTO   = 5'd8;
	localparam logic [KIND_W-1:0] K_CSUM    = 5'd9;
	localparam logic [KIND_W-1:0] K_V4SRC   = 5'd10;
	localparam logic [KIND_W-1:0] K_V4DST   = 5'd11;
	localparam logic [KIND_W-1:0] K_TC      = 5'd12;
	localparam logic [KIND_W-1:0] K_FLOW    = 5'd13;
	localparam logic [KIND_W-1:0] K_PAYLEN  = 5'd14;
	localparam logic [KIND_W-1:0] K_NEXTHDR = 5'd15;
	localparam logic [KIND_W-1:0] K_HOPLIM  = 5'd16;
	localparam logic [KIND_W-1:0] K_SRC_HI  = 5'd17;
	localparam logic [KIND_W-1:0] K_SRC_LO  = 5'd18;
	localparam logic [KIND_W-1:0] K_DST_HI  = 5'd19;
	localparam logic [KIND_W-1:0] K_DST_LO  = 5'd20;
	localparam logic [KIND_W-1:0] K_NONE    = 5'd21;

	// One finished packet, handed from capture to the record emitter.
	typedef struct packed {
		logic [HDR_SNAP_BYTES-1:0][7:0] hdr;
		logic [PKT_LEN_W-1:0]           len;
		logic                           v6;
		logic                           err;
		logic                           adv;
	} job_t;
endpackage
`default_nettype wire

FILE: sv/ihfe_capture.sv
`default_nettype none
module ihfe_capture #(
	parameter int HEADER_STORE_BYTES = 40,
	parameter int MAX_PACKET_BYTES   = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        acc,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_ipv6,
	input  wire logic        last_byte,
	output logic             launch,
	output ihfe_pkg::job_t   job
);
	import ihfe_pkg::*;

	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int SIDX_W = $clog2(HEADER_STORE_BYTES);

	logic [7:0]       hdr_q [HEADER_STORE_BYTES];
	logic [CNT_W-1:0] cnt_q;
	logic             store_en;
	logic             cnt_sat;
	logic [CNT_W-1:0] len;
	logic [HDR_SNAP_BYTES-1:0][7:0] snap;
	logic [3:0]       ihl;
	logic [5:0]       hlen;
	logic [PKT_LEN_W-1:0] len16;
	logic [PKT_LEN_W-1:0] hlen16;
	logic [PKT_LEN_W-1:0] tot;
	logic             v4_bad_hdr;
	logic             v4_bad_len;
	logic             v6_bad;

	assign store_en = cnt_q < CNT_W'(HEADER_STORE_BYTES);
	assign cnt_sat  = cnt_q >= CNT_W'(MAX_PACKET_BYTES);
	assign len      = cnt_sat ? cnt_q : cnt_q + CNT_W'(1);

	// merge the byte in flight so a last byte inside the header is seen
	always_comb begin
		for (int i = 0; i < HDR_SNAP_BYTES; i++) begin
			snap[i] = (store_en && cnt_q == CNT_W'(i)) ? data_byte : hdr_q[i];
		end
	end

	assign ihl    = snap[0][3:0];
	assign hlen   = {ihl, 2'b00};
	assign len16  = PKT_LEN_W'(len);
	assign hlen16 = PKT_LEN_W'(hlen);
	assign tot    = {snap[2], snap[3]};

	assign v4_bad_hdr = (ihl < IHL_MIN) || (len16 < hlen16);
	assign v4_bad_len = (tot < hlen16) || (tot > len16);
	assign v6_bad     = len16 < V6_MIN_LEN;

	assign launch  = acc && last_byte;
	assign job.hdr = snap;
	assign job.len = len16;
	assign job.v6  = is_ipv6;
	assign job.err = is_ipv6 ? v6_bad : (v4_bad_hdr || v4_bad_len);
	assign job.adv = is_ipv6 ? !v6_bad : !v4_bad_hdr;

	always_ff @(posedge clk) begin
		if (acc && store_en) begin
			hdr_q[cnt_q[SIDX_W-1:0]] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= last_byte ? '0 : len;
		end
	end
endmodule
`default_nettype wire

FILE: sv/ihfe_emit.sv
`default_nettype none
`include "ip_header_field_extractor_top_assert.svh"
module ihfe_emit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         launch,
	input  wire ihfe_pkg::job_t job,
	output logic              busy,
	output logic              done,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [4:0]        record_kind,
	output logic [63:0]       record_value,
	output logic              status,
	output logic              last_record,
	output logic [31:0]       packets_counted,
	output logic [63:0]       bytes_counted
);
	import ihfe_pkg::*;

	logic              job_valid_s1;
	job_t              job_s1;
	logic [IDX_W-1:0]  idx_q;
	logic [31:0]       v4_pk_q;
	logic [63:0]       v4_by_q;
	logic [31:0]       v6_pk_q;
	logic [63:0]       v6_by_q;
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [63:0]       value_q;
	logic              status_q;
	logic              last_q;
	logic [31:0]       pk_q;
	logic [63:0]       by_q;

	logic              load;
	logic [KIND_W-1:0] rec_kind;
	logic              rec_last;
	logic [63:0]       rec_value;
	logic [HDR_SNAP_BYTES-1:0][7:0] h;

	assign h    = job_s1.hdr;
	assign load = job_valid_s1 && (!out_valid_q || out_ready);
	assign done = load && rec_last;
	assign busy = job_valid_s1;

	always_comb begin
		if (job_s1.err) begin
			rec_kind = K_NONE;
			rec_last = 1'b1;
		end else if (job_s1.v6) begin
			rec_kind = (idx_q == '0) ? K_VERSION
				: KIND_W'({1'b0, idx_q}) + (K_TC - KIND_W'(1));
			rec_last = idx_q == V6_LAST_IDX;
		end else begin
			rec_kind = KIND_W'({1'b0, idx_q});
			rec_last = idx_q == V4_LAST_IDX;
		end
	end

	always_comb begin
		unique case (rec_kind)
			K_VERSION: rec_value = {60'd0, h[0][7:4]};
			K_IHL:     rec_value = {60'd0, h[0][3:0]};
			K_DSCP:    rec_value = {58'd0, h[1][7:2]};
			K_ECN:     rec_value = {62'd0, h[1][1:0]};
			K_TOTLEN:  rec_value = {48'd0, h[2], h[3]};
			K_ID:      rec_value = {48'd0, h[4], h[5]};
			K_FRAG:    rec_value = {48'd0, h[6], h[7]};
			K_TTL:     rec_value = {56'd0, h[8]};
			K_PROTO:   rec_value = {56'd0, h[9]};
			K_CSUM:    rec_value = {48'd0, h[10], h[11]};
			K_V4SRC:   rec_value = {32'd0, h[12], h[13], h[14], h[15]};
			K_V4DST:   rec_value = {32'd0, h[16], h[17], h[18], h[19]};
			K_TC:      rec_value = {56'd0, h[0][3:0], h[1][7:4]};
			K_FLOW:    rec_value = {44'd0, h[1][3:0], h[2], h[3]};
			K_PAYLEN:  rec_value = {48'd0, h[4], h[5]};
			K_NEXTHDR: rec_value = {56'd0, h[6]};
			K_HOPLIM:  rec_value = {56'd0, h[7]};
			K_SRC_HI:  rec_value = {h[8], h[9], h[10], h[11], h[12], h[13], h[14], h[15]};
			K_SRC_LO:  rec_value = {h[16], h[17], h[18], h[19], h[20], h[21], h[22], h[23]};
			K_DST_HI:  rec_value = {h[24], h[25], h[26], h[27], h[28], h[29], h[30], h[31]};
			K_DST_LO:  rec_value = {h[32], h[33], h[34], h[35], h[36], h[37], h[38], h[39]};
			default:   rec_value = '0;
		endcase
	end

	// job register and record index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (launch) begin
				job_valid_s1 <= 1'b1;
			end else if (done) begin
				job_valid_s1 <= 1'b0;
			end
			if (done) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			job_s1 <= job;
		end
	end

	// per-version totals advance as a packet with its adv flag set is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_pk_q <= '0;
			v4_by_q <= '0;
			v6_pk_q <= '0;
			v6_by_q <= '0;
		end else if (launch && job.adv) begin
			if (job.v6) begin
				v6_pk_q <= v6_pk_q + 32'd1;
				v6_by_q <= v6_by_q + 64'(job.len);
			end else begin
				v4_pk_q <= v4_pk_q + 32'd1;
				v4_by_q <= v4_by_q + 64'(job.len);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= rec_kind;
			value_q  <= rec_value;
			status_q <= job_s1.err;
			last_q   <= rec_last;
			pk_q     <= job_s1.v6 ? v6_pk_q : v4_pk_q;
			by_q     <= job_s1.v6 ? v6_by_q : v4_by_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign record_kind     = kind_q;
	assign record_value    = value_q;
	assign status          = status_q;
	assign last_record     = last_q;
	assign packets_counted = pk_q;
	assign bytes_counted   = by_q;

	`IHFE_ASSERT_IMP(a_no_overrun, clk, arst_n, launch, !job_valid_s1 || done)
	`IHFE_ASSERT_IMP(a_idx_range, clk, arst_n, job_valid_s1, idx_q <= V4_LAST_IDX)
	`IHFE_ASSERT_IMP(a_idx_idle, clk, arst_n, !job_valid_s1, idx_q == '0)
	`IHFE_ASSERT_IMP(a_err_single, clk, arst_n, out_valid_q && status_q, last_q && kind_q == K_NONE)
	`IHFE_ASSERT_NXT(a_done_frees, clk, arst_n, done && !launch, !job_valid_s1)
endmodule
`default_nettype wire

FILE: sv/ip_header_field_extractor_top.sv
// IP header field extractor: one packet byte per beat in, field records out.
// First record: the last byte's packet is registered into the emitter job register, then
// the record into the output register, which a held output delays. Throughput: one byte
// and one record per cycle, records only while out_ready is high. A last byte stalls while
// the previous packet still has records to hand out, longer under output back-pressure.
// Reset (arst_n low, async): byte count, totals and valids clear; header store is kept.
`default_nettype none
module ip_header_field_extractor_top #(
	parameter int HEADER_STORE_BYTES = 40,
	parameter int MAX_PACKET_BYTES   = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_ipv6,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       record_kind,
	output logic [63:0]      record_value,
	output logic             status,
	output logic             last_record,
	output logic [31:0]      packets_counted,
	output logic [63:0]      bytes_counted
);
	import ihfe_pkg::*;

	logic acc;
	logic launch;
	logic busy;
	logic done;
	job_t job;

	// Body bytes always flow; a closing beat waits only until the emitter
	// frees its job slot, which may happen in this very cycle.
	assign in_ready = !(last_byte && busy && !done);
	assign acc      = in_valid && in_ready;

	// Capture: header store, saturating byte count and length checks.
	ihfe_capture #(
		.HEADER_STORE_BYTES (HEADER_STORE_BYTES),
		.MAX_PACKET_BYTES   (MAX_PACKET_BYTES)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.data_byte (data_byte),
		.is_ipv6   (is_ipv6),
		.last_byte (last_byte),
		.launch    (launch),
		.job       (job)
	);

	// Emitter: holds the packet snapshot, advances totals, walks the record
	// list into the output register while capture already takes the next packet.
	ihfe_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.launch          (launch),
		.job             (job),
		.busy            (busy),
		.done            (done),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.record_kind     (record_kind),
		.record_value    (record_value),
		.status          (status),
		.last_record     (last_record),
		.packets_counted (packets_counted),
		.bytes_counted   (bytes_counted)
	);
endmodule
`default_nettype wire
